// ===== rtl/core/eeg_pkg.sv =====
// package for the extended euclid gcd block
// widths, defaults and sequencer state codes; no dependencies
`default_nettype none

package eeg_pkg;

  localparam int unsigned WidthDefault = 64;
  localparam int unsigned FieldWidth   = 64;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StDiv   = 6'b000010,
    StMulS  = 6'b000100,
    StMulT  = 6'b001000,
    StFix   = 6'b010000,
    StDone  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/eeg_if.sv =====
// valid/ready channel carrying the operand pair or the result triple
// depends on eeg_pkg for the field width
`default_nettype none

interface eeg_in_if;
  logic                             valid;
  logic                             ready;
  logic [eeg_pkg::FieldWidth-1:0]   operand_a;
  logic [eeg_pkg::FieldWidth-1:0]   operand_b;
  modport source (output valid, operand_a, operand_b, input ready);
  modport sink   (input valid, operand_a, operand_b, output ready);
endinterface

interface eeg_out_if;
  logic                             valid;
  logic                             ready;
  logic [eeg_pkg::FieldWidth-1:0]   common_divisor;
  logic [eeg_pkg::FieldWidth-1:0]   mult_a;
  logic [eeg_pkg::FieldWidth-1:0]   mult_b;
  modport source (output valid, common_divisor, mult_a, mult_b, input ready);
  modport sink   (input valid, common_divisor, mult_a, mult_b, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/extended_euclid_gcd.sv =====
// Extended Euclid gcd on unsigned WIDTH-bit operands: returns g, s, t with
// b*t - a*s = g modulo 2^WIDTH for nonzero b. One item at a time: in_ready is
// high only when idle. Each half-step divides one remainder by the other with
// a restoring shift-subtract divider (one quotient bit per step), then
// updates s and t with one shift-add multiplier, shared for both products.
// depends on eeg_pkg and the channel interfaces in eeg_if.sv
`default_nettype none

module extended_euclid_gcd #(
  parameter int unsigned WIDTH = eeg_pkg::WidthDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  eeg_in_if.sink     in_i,
  eeg_out_if.source  out_o
);

  localparam int unsigned CntW = $clog2(WIDTH + 1);

  eeg_pkg::state_e state_q, state_d;

  // working registers; side selects which remainder is the dividend
  logic [WIDTH-1:0] r0_q, r1_q, s0_q, s1_q, t0_q, t1_q;
  logic             side_q;   // 0: r0 /= r1, 1: r1 /= r0
  logic [WIDTH-1:0] quo_q;    // quotient, also multiplier shifter
  logic [WIDTH-1:0] rem_q;    // partial remainder
  logic [WIDTH-1:0] acc_q;    // product accumulator
  logic [WIDTH-1:0] mcand_q;  // shifted multiplicand
  logic [CntW-1:0]  cnt_q;
  logic [WIDTH-1:0] div_n;    // divisor

  assign div_n = side_q ? r0_q : r1_q;

  // divider step
  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   rem_sh;
  assign rem_sh = {rem_q, quo_q[WIDTH-1]};
  assign trial  = rem_sh - {1'b0, div_n};

  logic last;
  assign last = (cnt_q == CntW'(WIDTH - 1));

  assign in_i.ready  = (state_q == eeg_pkg::StIdle);
  assign out_o.valid = (state_q == eeg_pkg::StDone);
  assign out_o.common_divisor = eeg_pkg::FieldWidth'(r0_q);
  assign out_o.mult_a         = eeg_pkg::FieldWidth'(s0_q);
  assign out_o.mult_b         = eeg_pkg::FieldWidth'(t0_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      eeg_pkg::StIdle: if (in_i.valid) begin
        state_d = (in_i.operand_b[WIDTH-1:0] == '0) ? eeg_pkg::StFix : eeg_pkg::StDiv;
      end
      eeg_pkg::StDiv:  if (last) state_d = eeg_pkg::StMulS;
      eeg_pkg::StMulS: if (last) state_d = eeg_pkg::StMulT;
      eeg_pkg::StMulT: if (last) begin
        if (side_q == 1'b0 && rem_q == '0) state_d = eeg_pkg::StDone;
        else if (side_q == 1'b1 && rem_q == '0) state_d = eeg_pkg::StFix;
        else state_d = eeg_pkg::StDiv;
      end
      eeg_pkg::StFix:  state_d = eeg_pkg::StDone;
      eeg_pkg::StDone: if (out_o.ready) state_d = eeg_pkg::StIdle;
      default:         state_d = eeg_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eeg_pkg::StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) cnt_q <= '0;
      else cnt_q <= cnt_q + CntW'(1);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      eeg_pkg::StIdle: begin
        r0_q   <= in_i.operand_a[WIDTH-1:0];
        r1_q   <= in_i.operand_b[WIDTH-1:0];
        s0_q   <= WIDTH'(1);
        t0_q   <= '0;
        s1_q   <= '0;
        t1_q   <= WIDTH'(1);
        side_q <= 1'b0;
        rem_q  <= '0;
        quo_q  <= in_i.operand_a[WIDTH-1:0];
      end
      eeg_pkg::StDiv: begin
        // restoring step, quotient bits shift into quo_q
        if (!trial[WIDTH]) begin
          rem_q <= trial[WIDTH-1:0];
          quo_q <= {quo_q[WIDTH-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[WIDTH-1:0];
          quo_q <= {quo_q[WIDTH-2:0], 1'b0};
        end
        acc_q   <= side_q ? s1_q : s0_q;
        mcand_q <= side_q ? s0_q : s1_q;
      end
      eeg_pkg::StMulS, eeg_pkg::StMulT: begin
        // shift-add, quotient rotates through all WIDTH bit positions so it is intact for the next product
        if (!last) begin
          acc_q <= acc_q + (quo_q[0] ? mcand_q : '0);
          mcand_q <= {mcand_q[WIDTH-2:0], 1'b0};
        end
        quo_q <= {quo_q[0], quo_q[WIDTH-1:1]};
        if (last) begin
          if (state_q == eeg_pkg::StMulS) begin
            if (side_q) s1_q <= acc_q + (quo_q[0] ? mcand_q : '0);
            else        s0_q <= acc_q + (quo_q[0] ? mcand_q : '0);
            acc_q   <= side_q ? t1_q : t0_q;
            mcand_q <= side_q ? t0_q : t1_q;
          end else begin
            if (side_q) begin
              t1_q <= acc_q + (quo_q[0] ? mcand_q : '0);
              r1_q <= rem_q;
              quo_q <= r0_q;
            end else begin
              t0_q <= acc_q + (quo_q[0] ? mcand_q : '0);
              r0_q <= rem_q;
              quo_q <= r1_q;
              if (rem_q == '0) begin
                r0_q <= r1_q;
                s0_q <= s1_q;
                t0_q <= t1_q;
              end
            end
            side_q <= ~side_q;
            rem_q  <= '0;
          end
        end
      end
      eeg_pkg::StFix: begin
        if (s1_q > s0_q) begin
          s0_q <= s1_q - s0_q;
          t0_q <= t1_q - t0_q;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(r0_q))
    else $error("result lost before transfer");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("accepting while result pending");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == eeg_pkg::StDiv |-> cnt_q < CntW'(WIDTH))
    else $error("divider counter overrun");

endmodule

`default_nettype wire
